/* design/adaptive_interpolated_map_top_macros.svh */
// assertion macros used by the adaptive interpolated map controller
// needs i_clk and i_rst_n in the scope of each use
`ifndef ADAPTIVE_INTERPOLATED_MAP_TOP_MACROS_SVH
`define ADAPTIVE_INTERPOLATED_MAP_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define AIM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define AIM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/aim_pkg.sv */
// shared types and constants of the adaptive interpolated map
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package aim_pkg;

    // table size default and register reset values
    localparam int          MAX_POINTS_DEF = 16;
    localparam logic [4:0]  PC_RESET       = 5'd16;
    localparam logic [15:0] THR_RESET      = 16'd0;

    // shared divider widths
    localparam int DVD_W = 40;
    localparam int DVS_W = 27;
    localparam int QUO_W = 24;

    // quotient bit counts of the two divisions
    localparam logic [4:0] INTERP_QBITS = 5'd24;
    localparam logic [4:0] CORR_QBITS   = 5'd16;

    typedef enum logic [1:0] {
        FUNC_LOOKUP    = 2'd0,
        FUNC_ADAPT     = 2'd1,
        FUNC_WRITE_BP  = 2'd2,
        FUNC_WRITE_MAP = 2'd3
    } t_func;

    typedef enum logic {
        CFG_POINT_COUNT      = 1'b0,
        CFG_CHANGE_THRESHOLD = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIV_INTERP  = 2'd0,
        DIV_CORR_LO = 2'd1,
        DIV_CORR_HI = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     capture;
        logic     wr_entry;
        logic     lat_lo;
        logic     lat_hi;
        logic     calc_pq;
        logic     calc_mul;
        logic     div_start;
        t_div_sel div_sel;
        logic     calc_interp;
        logic     calc_d;
        logic     calc_mul2;
        logic     calc_sig;
        logic     wr_map_lo;
        logic     wr_map_hi;
        logic     same_idx;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  x_le;
        logic  x_ge;
        logic  x_lt;
        logic  div_busy;
    } t_status;

endpackage

`default_nettype wire

/* design/aim_div.sv */
// restoring divider, one quotient bit per cycle
// depends on aim_pkg
`timescale 1ns / 1ps
`default_nettype none

module aim_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [aim_pkg::DVD_W-1:0]   i_dividend,
    input  wire logic [aim_pkg::DVS_W-1:0]   i_divisor,
    input  wire logic [4:0]                  i_qbits,
    output logic                             o_busy,
    output logic      [aim_pkg::QUO_W-1:0]   o_quotient
);

    localparam int DW = aim_pkg::DVS_W;
    localparam int QW = aim_pkg::QUO_W;

    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_quo;
    logic [4:0]    r_cnt;
    logic          r_busy;
    logic [DW+1:0] w_diff;
    logic          w_ge;

    // trial subtract of the divisor from the shifted remainder
    assign w_diff = {1'b0, r_rem, r_quo[QW-1]} - {2'b00, i_divisor};
    assign w_ge   = !w_diff[DW+1];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= (i_qbits != 5'd0);
            r_cnt  <= i_qbits;
        end else if (r_busy) begin
            r_busy <= (r_cnt != 5'd1);
            r_cnt  <= r_cnt - 5'd1;
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DW'(i_dividend >> i_qbits);
            r_quo <= QW'(i_dividend) << (5'(QW) - i_qbits);
        end else if (r_busy) begin
            r_rem <= w_ge ? DW'(w_diff) : DW'({r_rem, r_quo[QW-1]});
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* design/aim_datapath.sv */
// tables, arithmetic and output word register of the interpolated map
// depends on aim_pkg and aim_div
`timescale 1ns / 1ps
`default_nettype none

module aim_datapath #(
    parameter int MAX_POINTS = aim_pkg::MAX_POINTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire aim_pkg::t_cmd                 i_cmd,
    input  wire logic [$clog2(MAX_POINTS)-1:0] i_rd_addr,
    input  wire logic [$clog2(MAX_POINTS)-1:0] i_wr_addr,
    output aim_pkg::t_status                   o_status,
    input  wire logic [15:0]                   i_change_threshold,
    input  wire logic [1:0]                    i_func,
    input  wire logic signed [15:0]            i_x_value,
    input  wire logic signed [15:0]            i_sample,
    input  wire logic [3:0]                    i_entry_index,
    input  wire logic signed [15:0]            i_entry_value,
    output logic signed [23:0]                 o_interp_value,
    output logic                               o_significant
);

    localparam int AW = $clog2(MAX_POINTS);

    function automatic logic signed [15:0] f_sat16(input logic signed [17:0] v);
        logic signed [15:0] res;
        if (v > 18'sd32767)       res = 16'sh7fff;
        else if (v < -18'sd32768) res = 16'sh8000;
        else                      res = 16'(v);
        return res;
    endfunction

    // captured item
    aim_pkg::t_func     r_func;
    logic signed [15:0] r_x;
    logic signed [15:0] r_sample;
    logic [3:0]         r_idx;
    logic signed [15:0] r_entry;

    // tables
    logic signed [15:0] r_bp_mem  [MAX_POINTS];
    logic signed [15:0] r_map_mem [MAX_POINTS];
    logic signed [15:0] r_bp_rd;
    logic signed [15:0] r_map_rd;

    // working registers
    logic signed [15:0] r_x1, r_x2, r_ylo, r_yhi;
    logic [15:0]        r_p, r_q, r_qmp;
    logic [15:0]        r_dy_mag;
    logic               r_dy_neg;
    logic [31:0]        r_prod_i;
    logic signed [23:0] r_interp;
    logic [23:0]        r_d_mag;
    logic               r_d_neg;
    logic [39:0]        r_prod_lo, r_prod_hi;
    logic [26:0]        r_div1280;
    logic [38:0]        r_thr_prod;
    logic               r_sig;
    logic signed [15:0] r_newlo;
    logic signed [23:0] r_out_interp;
    logic               r_out_sig;

    // combinational helpers
    logic signed [16:0] w_px, w_qx, w_dy;
    logic signed [24:0] w_ylo_s, w_int_sum;
    logic signed [25:0] w_d, w_d_abs;
    logic signed [17:0] w_corr, w_upd;
    logic signed [15:0] w_base, w_new;
    logic               w_in_range;
    logic               w_bp_we, w_map_we;
    logic [AW-1:0]      w_map_addr;
    logic signed [15:0] w_map_data;
    logic [aim_pkg::DVD_W-1:0] w_dividend;
    logic [aim_pkg::DVS_W-1:0] w_divisor;
    logic [4:0]         w_qbits;
    logic               w_div_busy;
    logic [aim_pkg::QUO_W-1:0] w_quo;

    // differences and sums
    assign w_px      = $signed({r_x[15], r_x}) - $signed({r_x1[15], r_x1});
    assign w_qx      = $signed({r_x2[15], r_x2}) - $signed({r_x1[15], r_x1});
    assign w_dy      = $signed({r_yhi[15], r_yhi}) - $signed({r_ylo[15], r_ylo});
    assign w_ylo_s   = $signed({r_ylo[15], r_ylo, 8'h00});
    assign w_int_sum = r_dy_neg ? (w_ylo_s - $signed({1'b0, w_quo}))
                                : (w_ylo_s + $signed({1'b0, w_quo}));
    assign w_d       = $signed({{2{r_sample[15]}}, r_sample, 8'h00})
                     - $signed({{2{r_interp[23]}}, r_interp});
    assign w_d_abs   = w_d[25] ? -w_d : w_d;

    // correction step of adapt
    assign w_corr = r_d_neg ? -$signed({2'b00, w_quo[15:0]}) : $signed({2'b00, w_quo[15:0]});
    assign w_base = i_cmd.wr_map_hi ? (i_cmd.same_idx ? r_newlo : r_yhi) : r_ylo;
    assign w_upd  = $signed({{2{w_base[15]}}, w_base}) + w_corr;
    assign w_new  = f_sat16(w_upd);

    // table write ports
    assign w_in_range = (32'(r_idx) < MAX_POINTS);
    assign w_bp_we    = i_cmd.wr_entry && w_in_range && (r_func == aim_pkg::FUNC_WRITE_BP);
    assign w_map_we   = (i_cmd.wr_entry && w_in_range && (r_func == aim_pkg::FUNC_WRITE_MAP))
                      || i_cmd.wr_map_lo || i_cmd.wr_map_hi;
    assign w_map_addr = i_cmd.wr_entry ? AW'(r_idx) : i_wr_addr;
    assign w_map_data = i_cmd.wr_entry ? r_entry : w_new;

    always_ff @(posedge i_clk) begin
        if (w_bp_we) begin
            r_bp_mem[AW'(r_idx)] <= r_entry;
        end
        r_bp_rd <= r_bp_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            r_map_mem[w_map_addr] <= w_map_data;
        end
        r_map_rd <= r_map_mem[i_rd_addr];
    end

    // divider operand select
    always_comb begin
        case (i_cmd.div_sel)
            aim_pkg::DIV_CORR_LO: begin
                w_dividend = r_prod_lo;
                w_divisor  = r_div1280;
                w_qbits    = aim_pkg::CORR_QBITS;
            end
            aim_pkg::DIV_CORR_HI: begin
                w_dividend = r_prod_hi;
                w_divisor  = r_div1280;
                w_qbits    = aim_pkg::CORR_QBITS;
            end
            default: begin
                w_dividend = {r_prod_i, 8'h00};
                w_divisor  = {11'd0, r_q};
                w_qbits    = aim_pkg::INTERP_QBITS;
            end
        endcase
    end

    aim_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .i_qbits    (w_qbits),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    // item capture and arithmetic steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= aim_pkg::t_func'(i_func);
            r_x      <= i_x_value;
            r_sample <= i_sample;
            r_idx    <= i_entry_index;
            r_entry  <= i_entry_value;
            r_interp <= '0;
            r_sig    <= 1'b0;
        end
        if (i_cmd.lat_lo) begin
            r_x1  <= r_bp_rd;
            r_ylo <= r_map_rd;
        end
        if (i_cmd.lat_hi) begin
            r_x2  <= r_bp_rd;
            r_yhi <= r_map_rd;
        end
        if (i_cmd.calc_pq) begin
            if (r_x2 > r_x1) begin
                r_p <= 16'(w_px);
                r_q <= 16'(w_qx);
            end else begin
                r_p <= 16'd0;
                r_q <= 16'd1;
            end
            r_dy_neg <= w_dy[16];
            r_dy_mag <= 16'(w_dy[16] ? -w_dy : w_dy);
        end
        if (i_cmd.calc_mul) begin
            r_prod_i <= r_dy_mag * r_p;
        end
        if (i_cmd.calc_interp) begin
            r_interp <= 24'(w_int_sum);
        end
        if (i_cmd.calc_d) begin
            r_d_neg <= w_d[25];
            r_d_mag <= 24'(w_d_abs);
            r_qmp   <= r_q - r_p;
        end
        if (i_cmd.calc_mul2) begin
            r_prod_lo  <= r_d_mag * r_qmp;
            r_prod_hi  <= r_d_mag * r_p;
            r_div1280  <= {1'b0, r_q, 10'd0} + {3'd0, r_q, 8'd0};
            r_thr_prod <= i_change_threshold * r_interp[22:0];
        end
        if (i_cmd.calc_sig) begin
            if (!r_interp[23] && (r_interp != '0)) begin
                r_sig <= ({8'd0, r_d_mag, 8'd0} > {1'b0, r_thr_prod});
            end else if (r_interp == '0) begin
                r_sig <= (r_d_mag != '0);
            end else begin
                r_sig <= 1'b0;
            end
        end
        if (i_cmd.wr_map_lo) begin
            r_newlo <= w_new;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_interp <= r_interp;
            r_out_sig    <= r_sig;
        end
    end

    // status back to the controller
    always_comb begin
        o_status.func     = r_func;
        o_status.x_le     = (r_x <= r_bp_rd);
        o_status.x_ge     = (r_x >= r_bp_rd);
        o_status.x_lt     = (r_x < r_bp_rd);
        o_status.div_busy = w_div_busy;
    end

    assign o_interp_value = r_out_interp;
    assign o_significant  = r_out_sig;

endmodule

`default_nettype wire

/* design/aim_ctrl.sv */
// sequencer of the interpolated map: breakpoint search, division and update steps
// depends on aim_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "adaptive_interpolated_map_top_macros.svh"

module aim_ctrl #(
    parameter int MAX_POINTS = aim_pkg::MAX_POINTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [4:0]                    i_point_count,
    input  wire aim_pkg::t_status              i_status,
    output aim_pkg::t_cmd                      o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0]      o_rd_addr,
    output logic [$clog2(MAX_POINTS)-1:0]      o_wr_addr
);

    localparam int AW = $clog2(MAX_POINTS);

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_CHK0, S_CHKN, S_SCAN_RD, S_SCAN_CHK,
        S_RD_LO, S_RD_HI, S_LAT_HI, S_PQ, S_MUL, S_DIVI, S_DIVI_W, S_INTERP,
        S_D, S_MUL2, S_SIG, S_DIVL, S_DIVL_W, S_WRL, S_DIVH, S_DIVH_W, S_WRH,
        S_FINISH
    } t_state;

    t_state        r_state;
    logic          r_out_valid;
    logic [AW-1:0] r_i, r_lo, r_hi;
    logic [AW-1:0] w_last;

    // last index in use, count clamped to one and to the table size
    always_comb begin
        if (i_point_count == 5'd0)                w_last = '0;
        else if (32'(i_point_count) >= MAX_POINTS) w_last = AW'(MAX_POINTS - 1);
        else                                      w_last = AW'(i_point_count - 5'd1);
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FINISH && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_START;
                end
                S_START: begin
                    if (i_status.func == aim_pkg::FUNC_WRITE_BP ||
                        i_status.func == aim_pkg::FUNC_WRITE_MAP) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_CHK0;
                    end
                end
                S_CHK0: begin
                    if (i_status.x_le) begin
                        r_lo    <= '0;
                        r_hi    <= '0;
                        r_state <= S_RD_LO;
                    end else begin
                        r_state <= S_CHKN;
                    end
                end
                S_CHKN: begin
                    if (i_status.x_ge) begin
                        r_lo    <= w_last;
                        r_hi    <= w_last;
                        r_state <= S_RD_LO;
                    end else begin
                        r_i     <= AW'(1);
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    if (i_status.x_lt || r_i == w_last) begin
                        r_lo    <= r_i - AW'(1);
                        r_hi    <= r_i;
                        r_state <= S_RD_LO;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= S_SCAN_RD;
                    end
                end
                S_RD_LO:  r_state <= S_RD_HI;
                S_RD_HI:  r_state <= S_LAT_HI;
                S_LAT_HI: r_state <= S_PQ;
                S_PQ:     r_state <= S_MUL;
                S_MUL:    r_state <= S_DIVI;
                S_DIVI:   r_state <= S_DIVI_W;
                S_DIVI_W: begin
                    if (!i_status.div_busy) r_state <= S_INTERP;
                end
                S_INTERP: begin
                    r_state <= (i_status.func == aim_pkg::FUNC_ADAPT) ? S_D : S_FINISH;
                end
                S_D:      r_state <= S_MUL2;
                S_MUL2:   r_state <= S_SIG;
                S_SIG:    r_state <= S_DIVL;
                S_DIVL:   r_state <= S_DIVL_W;
                S_DIVL_W: begin
                    if (!i_status.div_busy) r_state <= S_WRL;
                end
                S_WRL:    r_state <= S_DIVH;
                S_DIVH:   r_state <= S_DIVH_W;
                S_DIVH_W: begin
                    if (!i_status.div_busy) r_state <= S_WRH;
                end
                S_WRH:    r_state <= S_FINISH;
                S_FINISH: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    // command decode
    always_comb begin
        o_cmd             = '0;
        o_cmd.div_sel     = aim_pkg::DIV_INTERP;
        o_rd_addr         = '0;
        o_wr_addr         = r_lo;
        o_cmd.capture     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.wr_entry    = (r_state == S_START);
        o_cmd.lat_lo      = (r_state == S_RD_HI);
        o_cmd.lat_hi      = (r_state == S_LAT_HI);
        o_cmd.calc_pq     = (r_state == S_PQ);
        o_cmd.calc_mul    = (r_state == S_MUL);
        o_cmd.calc_interp = (r_state == S_INTERP);
        o_cmd.calc_d      = (r_state == S_D);
        o_cmd.calc_mul2   = (r_state == S_MUL2);
        o_cmd.calc_sig    = (r_state == S_SIG);
        o_cmd.wr_map_lo   = (r_state == S_WRL);
        o_cmd.wr_map_hi   = (r_state == S_WRH);
        o_cmd.same_idx    = (r_lo == r_hi);
        o_cmd.out_load    = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);
        case (r_state)
            S_CHK0:    o_rd_addr = w_last;
            S_SCAN_RD: o_rd_addr = r_i;
            S_RD_LO:   o_rd_addr = r_lo;
            S_RD_HI:   o_rd_addr = r_hi;
            S_DIVI:    o_cmd.div_start = 1'b1;
            S_DIVL: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = aim_pkg::DIV_CORR_LO;
            end
            S_DIVL_W:  o_cmd.div_sel = aim_pkg::DIV_CORR_LO;
            S_DIVH: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = aim_pkg::DIV_CORR_HI;
            end
            S_DIVH_W:  o_cmd.div_sel = aim_pkg::DIV_CORR_HI;
            S_WRH:     o_wr_addr = r_hi;
            default:   o_rd_addr = '0;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // checks
    `AIM_ASSERT_NXT(a_div_runs, o_cmd.div_start, i_status.div_busy, "divider did not start")
    `AIM_ASSERT_IMP(a_scan_bound, r_state == S_SCAN_CHK, (r_i <= w_last) && (r_i != '0), "scan index out of range")
    `AIM_ASSERT_IMP(a_bracket, r_state == S_RD_LO, (r_hi == r_lo) || (r_hi == r_lo + AW'(1)), "bad bracket")
    `AIM_ASSERT_IMP(a_map_upd_adapt, o_cmd.wr_map_lo || o_cmd.wr_map_hi, i_status.func == aim_pkg::FUNC_ADAPT, "map update outside adapt")
    `AIM_ASSERT_IMP(a_out_no_overwrite, o_cmd.out_load, !r_out_valid || i_out_ready, "pending result overwritten")

endmodule

`default_nettype wire

/* design/adaptive_interpolated_map_top.sv */
// adaptive interpolated map: one item at a time, next item taken once the result is registered
// table writes skip the search; lookup time is set by the breakpoint
// scan (a read and a check per entry through the registered table read) and the 24-step divider
// adapt adds the deviation, two 16-step divisions and the two map updates
// synchronous active-low reset clears control and the config registers (count 16, threshold 0)
// tables hold no reset value; depends on aim_pkg, aim_ctrl, aim_datapath
`timescale 1ns / 1ps
`default_nettype none

module adaptive_interpolated_map_top #(
    parameter int MAX_POINTS = aim_pkg::MAX_POINTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_func,
    input  wire logic signed [15:0] i_x_value,
    input  wire logic signed [15:0] i_sample,
    input  wire logic [3:0]         i_entry_index,
    input  wire logic signed [15:0] i_entry_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [23:0]      o_interp_value,
    output logic                    o_significant
);

    localparam int AW = $clog2(MAX_POINTS);

    logic [4:0]       r_point_count;
    logic [15:0]      r_change_threshold;
    aim_pkg::t_cmd    w_cmd;
    aim_pkg::t_status w_status;
    logic [AW-1:0]    w_rd_addr, w_wr_addr;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count      <= aim_pkg::PC_RESET;
            r_change_threshold <= aim_pkg::THR_RESET;
        end else if (i_cfg_valid) begin
            case (aim_pkg::t_cfg_idx'(i_cfg_index))
                aim_pkg::CFG_POINT_COUNT:      r_point_count      <= i_cfg_data[4:0];
                aim_pkg::CFG_CHANGE_THRESHOLD: r_change_threshold <= i_cfg_data;
                default:                       r_point_count      <= r_point_count;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    aim_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_point_count (r_point_count),
        .i_status      (w_status),
        .o_cmd         (w_cmd),
        .o_rd_addr     (w_rd_addr),
        .o_wr_addr     (w_wr_addr)
    );

    aim_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_rd_addr          (w_rd_addr),
        .i_wr_addr          (w_wr_addr),
        .o_status           (w_status),
        .i_change_threshold (r_change_threshold),
        .i_func             (i_func),
        .i_x_value          (i_x_value),
        .i_sample           (i_sample),
        .i_entry_index      (i_entry_index),
        .i_entry_value      (i_entry_value),
        .o_interp_value     (o_interp_value),
        .o_significant      (o_significant)
    );

endmodule

`default_nettype wire
